// File: hdl/cbtc_pkg.sv
// ----------------------------------------------------------------------------
// cbtc_pkg
// Types and constants shared by the bilinear correction table block.
// ----------------------------------------------------------------------------
package cbtc_pkg;

  localparam int unsigned ValW = 24;
  localparam int unsigned IdxW = 6;
  localparam int unsigned PtsW = 7;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] RegAngleMin   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegAngleMax   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegAngleStep  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegAnglePts   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegLossMin    = 3'd4;
  localparam logic [CfgIdxW-1:0] RegLossMax    = 3'd5;
  localparam logic [CfgIdxW-1:0] RegLossStep   = 3'd6;
  localparam logic [CfgIdxW-1:0] RegLossPts    = 3'd7;

  localparam logic OpWrite   = 1'b0;
  localparam logic OpCorrect = 1'b1;

  typedef struct packed {
    logic            operation;
    logic [ValW-1:0] angle;
    logic [ValW-1:0] loss;
    logic [IdxW-1:0] row_index;
    logic [IdxW-1:0] column_index;
    logic [ValW-1:0] entry_value;
  } in_item_t;

  typedef struct packed {
    logic [ValW-1:0] factor;
    logic [ValW-1:0] corrected_loss;
    logic            saturated;
    logic            write_done;
  } out_item_t;

  typedef struct packed {
    logic [ValW-1:0] amin;
    logic [ValW-1:0] amax;
    logic [ValW-1:0] astep;
    logic [PtsW-1:0] apts;
    logic [ValW-1:0] lmin;
    logic [ValW-1:0] lmax;
    logic [ValW-1:0] lstep;
    logic [PtsW-1:0] lpts;
  } cfg_t;

endpackage

// File: hdl/clamped_bilinear_table_correction_top.sv
// A write or zero-loss item skips the bin search and the table reads; other
// corrections take up to two bin divides in front, then four table reads and
// three blend steps through one shared divider in back. The back sets the
// pace; a two-entry queue lets the front search bins meanwhile, and the front
// takes a new item once it has queued the last. Reset returns the grid
// registers to their defaults; table contents are undefined until written.
// ----------------------------------------------------------------------------
// clamped_bilinear_table_correction_top
// Bilinear correction on a clamped uniform grid with a written table.
// ----------------------------------------------------------------------------
module clamped_bilinear_table_correction_top
  import cbtc_pkg::*;
#(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [ValW-1:0]    cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_item_t           in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_item_t          out_item_o
);

  cfg_t cfg_q;
  logic            jv, jt;
  in_item_t        ji;
  logic [IdxW-1:0] alo, ahi, llo, lhi;
  logic [ValW-1:0] aoff, astep, loff, lstep;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{amin: '0, amax: ValW'(11796480), astep: ValW'(65536), apts: PtsW'(1),
                 lmin: '0, lmax: '1, lstep: ValW'(65536), lpts: PtsW'(1)};
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegAngleMin:  cfg_q.amin  <= cfg_data_i;
        RegAngleMax:  cfg_q.amax  <= cfg_data_i;
        RegAngleStep: cfg_q.astep <= cfg_data_i;
        RegAnglePts:  cfg_q.apts  <= cfg_data_i[PtsW-1:0];
        RegLossMin:   cfg_q.lmin  <= cfg_data_i;
        RegLossMax:   cfg_q.lmax  <= cfg_data_i;
        RegLossStep:  cfg_q.lstep <= cfg_data_i;
        RegLossPts:   cfg_q.lpts  <= cfg_data_i[PtsW-1:0];
        default: ;
      endcase
    end
  end

  cbtc_front u_front (
    .clk_i, .rst_ni, .cfg_i(cfg_q),
    .in_valid_i, .in_stall_o, .in_i(in_item_i),
    .job_valid_o(jv), .job_take_i(jt), .job_item_o(ji),
    .job_alo_o(alo), .job_ahi_o(ahi), .job_aoff_o(aoff), .job_astep_o(astep),
    .job_llo_o(llo), .job_lhi_o(lhi), .job_loff_o(loff), .job_lstep_o(lstep)
  );

  cbtc_back #(.FracBits(FRACTION_BITS)) u_back (
    .clk_i, .rst_ni,
    .job_valid_i(jv), .job_take_o(jt), .job_item_i(ji),
    .job_alo_i(alo), .job_ahi_i(ahi), .job_aoff_i(aoff), .job_astep_i(astep),
    .job_llo_i(llo), .job_lhi_i(lhi), .job_loff_i(loff), .job_lstep_i(lstep),
    .out_valid_o, .out_stall_i, .out_o(out_item_o)
  );

endmodule

// File: hdl/cbtc_div.sv
// ----------------------------------------------------------------------------
// cbtc_div
// Restoring divider, one quotient bit per cycle, quotient and remainder.
// ----------------------------------------------------------------------------
module cbtc_div
  import cbtc_pkg::*;
#(
  parameter int unsigned NumW = 48,
  parameter int unsigned DenW = 24
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            busy_o,
  output logic            done_o,
  output logic [NumW-1:0] quo_o,
  output logic [DenW-1:0] rem_o
);

  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [NumW-1:0] quo_q, quo_d;
  logic [DenW:0]   rem_q, rem_d;
  logic [DenW-1:0] den_q, den_d;
  logic [DenW:0]   shifted;
  logic [DenW:0]   diff;

  assign shifted = {rem_q[DenW-1:0], quo_q[NumW-1]};
  assign diff    = shifted - {1'b0, den_q};

  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(NumW);
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      if (!diff[DenW]) begin
        rem_d = diff;
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q[DenW-1:0];

endmodule

// File: hdl/cbtc_front.sv
// ----------------------------------------------------------------------------
// cbtc_front
// Accept items, clamp angle and loss of nonzero-loss corrections to grid bins and queue them.
// ----------------------------------------------------------------------------
module cbtc_front
  import cbtc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_i,
  output logic     job_valid_o,
  input  logic     job_take_i,
  output in_item_t job_item_o,
  output logic [IdxW-1:0] job_alo_o,
  output logic [IdxW-1:0] job_ahi_o,
  output logic [ValW-1:0] job_aoff_o,
  output logic [ValW-1:0] job_astep_o,
  output logic [IdxW-1:0] job_llo_o,
  output logic [IdxW-1:0] job_lhi_o,
  output logic [ValW-1:0] job_loff_o,
  output logic [ValW-1:0] job_lstep_o
);

  typedef enum logic [1:0] {StIdle, StAngle, StLoss, StPush} st_e;

  st_e st_q;
  in_item_t item_q;
  logic [IdxW-1:0] alo_q, ahi_q, llo_q, lhi_q;
  logic [ValW-1:0] aoff_q, loff_q, astep_q, lstep_q;
  logic [IdxW-1:0] lasta, lastl;
  logic [PtsW-1:0] apc, lpc;

  logic            dv_start, dv_busy, dv_done;
  logic [ValW-1:0] dv_num, dv_den, dv_quo, dv_rem;

  logic [ValW-1:0] x, lo, hi;
  logic [IdxW-1:0] last;
  logic [ValW-1:0] astp, lstp;

  logic fifo_full;

  always_comb begin
    apc = (cfg_i.apts == '0) ? PtsW'(1) : cfg_i.apts;
    if (apc > PtsW'(64)) apc = PtsW'(64);
    lpc = (cfg_i.lpts == '0) ? PtsW'(1) : cfg_i.lpts;
    if (lpc > PtsW'(64)) lpc = PtsW'(64);
    lasta = IdxW'(apc - 1'b1);
    lastl = IdxW'(lpc - 1'b1);
    astp = (cfg_i.astep == '0) ? ValW'(1) : cfg_i.astep;
    lstp = (cfg_i.lstep == '0) ? ValW'(1) : cfg_i.lstep;
  end

  always_comb begin
    if (st_q == StAngle) begin
      x = item_q.angle; lo = cfg_i.amin; hi = cfg_i.amax; last = lasta;
    end else begin
      x = item_q.loss; lo = cfg_i.lmin; hi = cfg_i.lmax; last = lastl;
    end
  end

  assign dv_num = x - lo;
  assign dv_den = (st_q == StAngle) ? astp : lstp;
  assign dv_start = (st_q == StAngle || st_q == StLoss) && !dv_busy && !dv_done
                    && (x > lo) && (x < hi);

  cbtc_div #(.NumW(ValW), .DenW(ValW)) u_div (
    .clk_i, .rst_ni, .start_i(dv_start), .num_i(dv_num), .den_i(dv_den),
    .busy_o(dv_busy), .done_o(dv_done), .quo_o(dv_quo), .rem_o(dv_rem)
  );

  logic            ax_ready;
  logic [IdxW-1:0] b_lo, b_hi;
  logic [ValW-1:0] b_off;

  always_comb begin
    ax_ready = 1'b0;
    b_lo = '0; b_hi = '0; b_off = '0;
    if (x <= lo) begin
      ax_ready = 1'b1;
    end else if (x >= hi) begin
      ax_ready = 1'b1; b_lo = last; b_hi = last;
    end else if (dv_done) begin
      ax_ready = 1'b1;
      if (dv_quo >= ValW'(last)) begin
        b_lo = last; b_hi = last;
      end else begin
        b_lo = IdxW'(dv_quo); b_hi = IdxW'(dv_quo) + 1'b1; b_off = dv_rem;
      end
    end
  end

  localparam int unsigned JobW = $bits(in_item_t) + 4*IdxW + 4*ValW;
  logic [JobW-1:0] fifo_q [2];
  logic [1:0] cnt_q;
  logic       wp_q, rp_q;
  logic       push, pop;
  logic [JobW-1:0] job;

  assign in_stall_o = (st_q != StIdle);
  assign push = (st_q == StPush) && !fifo_full;
  assign fifo_full = (cnt_q == 2'd2);
  assign pop = job_take_i && (cnt_q != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
    end else begin
      unique case (st_q)
        StIdle: if (in_valid_i) begin
          st_q <= (in_i.operation == OpWrite || in_i.loss == '0) ? StPush : StAngle;
        end
        StAngle: if (ax_ready) st_q <= StLoss;
        StLoss: if (ax_ready) st_q <= StPush;
        StPush: if (!fifo_full) st_q <= StIdle;
        default: st_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == StIdle && in_valid_i) begin
      item_q <= in_i;
      alo_q <= '0; ahi_q <= '0; aoff_q <= '0;
      llo_q <= '0; lhi_q <= '0; loff_q <= '0;
      astep_q <= astp; lstep_q <= lstp;
    end
    if (st_q == StAngle && ax_ready) begin
      alo_q <= b_lo; ahi_q <= b_hi; aoff_q <= b_off;
    end
    if (st_q == StLoss && ax_ready) begin
      llo_q <= b_lo; lhi_q <= b_hi; loff_q <= b_off;
    end
  end

  assign job = {item_q, alo_q, ahi_q, aoff_q, astep_q, llo_q, lhi_q, loff_q, lstep_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; wp_q <= 1'b0; rp_q <= 1'b0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wp_q] <= job;
  end

  assign job_valid_o = (cnt_q != 2'd0);
  assign {job_item_o, job_alo_o, job_ahi_o, job_aoff_o, job_astep_o,
          job_llo_o, job_lhi_o, job_loff_o, job_lstep_o} = fifo_q[rp_q];

endmodule

// File: hdl/cbtc_back.sv
// ----------------------------------------------------------------------------
// cbtc_back
// Write the table, or read corners, blend by loss then angle, scale the loss.
// ----------------------------------------------------------------------------
module cbtc_back
  import cbtc_pkg::*;
#(
  parameter int unsigned FracBits = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      job_valid_i,
  output logic      job_take_o,
  input  in_item_t  job_item_i,
  input  logic [IdxW-1:0] job_alo_i,
  input  logic [IdxW-1:0] job_ahi_i,
  input  logic [ValW-1:0] job_aoff_i,
  input  logic [ValW-1:0] job_astep_i,
  input  logic [IdxW-1:0] job_llo_i,
  input  logic [IdxW-1:0] job_lhi_i,
  input  logic [ValW-1:0] job_loff_i,
  input  logic [ValW-1:0] job_lstep_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_o
);

  typedef enum logic [3:0] {
    StIdle, StRd0, StRd1, StRd2, StRd3, StWait, StBlendLo, StBlendHi,
    StBlendA, StMul, StOut
  } st_e;

  localparam int unsigned AddrW = 2*IdxW;
  localparam int unsigned NumW = 2*ValW + 2;

  st_e st_q, mst_q;
  logic [ValW-1:0] mem_q [2**AddrW];
  logic [ValW-1:0] rd_q;
  logic [AddrW-1:0] raddr;
  logic [ValW-1:0] e_q [4];
  logic [ValW-1:0] clo_q, chi_q, fac_q;
  logic [2*ValW-1:0] prod_q;
  logic [2*ValW:0] round;
  out_item_t out_q;
  logic out_valid_q;

  always_comb begin
    unique case (st_q)
      StRd0:   raddr = {job_llo_i, job_alo_i};
      StRd1:   raddr = {job_lhi_i, job_alo_i};
      StRd2:   raddr = {job_llo_i, job_ahi_i};
      default: raddr = {job_lhi_i, job_ahi_i};
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (st_q == StIdle && job_valid_i && job_item_i.operation == OpWrite) begin
      mem_q[{job_item_i.row_index, job_item_i.column_index}] <= job_item_i.entry_value;
    end
    rd_q <= mem_q[raddr];
  end

  // shared blend unit: (a*(s-d) + b*d + s/2) / s
  logic            dv_start, dv_busy, dv_done;
  logic [NumW-1:0] dv_num, dv_quo;
  logic [ValW-1:0] dv_den, dv_rem;
  logic [ValW-1:0] ba, bb, bd, bs;
  logic [2*ValW-1:0] m1_q, m2_q;
  logic            mphase_q;

  always_comb begin
    unique case (st_q)
      StBlendLo: begin ba = e_q[0]; bb = e_q[1]; bd = job_loff_i; bs = job_lstep_i; end
      StBlendHi: begin ba = e_q[2]; bb = e_q[3]; bd = job_loff_i; bs = job_lstep_i; end
      default:   begin ba = clo_q; bb = chi_q; bd = job_aoff_i; bs = job_astep_i; end
    endcase
  end

  assign dv_num = NumW'(m1_q) + NumW'(m2_q) + NumW'(bs >> 1);
  assign dv_den = bs;
  assign dv_start = mphase_q && (mst_q == st_q) && !dv_busy && !dv_done;

  cbtc_div #(.NumW(NumW), .DenW(ValW)) u_div (
    .clk_i, .rst_ni, .start_i(dv_start), .num_i(dv_num), .den_i(dv_den),
    .busy_o(dv_busy), .done_o(dv_done), .quo_o(dv_quo), .rem_o(dv_rem)
  );

  logic [ValW-1:0] one_fac;
  logic            one_sat;
  assign one_sat = (FracBits >= ValW);
  assign one_fac = one_sat ? '1 : ValW'(1) << FracBits;

  assign round = {1'b0, prod_q} + ((2*ValW+1)'(1) << (FracBits - 1));
  assign job_take_o = (st_q == StOut) && !out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      mst_q <= StIdle;
      out_valid_q <= 1'b0;
      mphase_q <= 1'b0;
    end else begin
      mst_q <= st_q;
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      unique case (st_q)
        StIdle: if (job_valid_i) begin
          if (job_item_i.operation == OpWrite || job_item_i.loss == '0) begin
            st_q <= StMul;
          end else begin
            st_q <= StRd0;
          end
        end
        StRd0: st_q <= StRd1;
        StRd1: st_q <= StRd2;
        StRd2: st_q <= StRd3;
        StRd3: st_q <= StWait;
        StWait: begin st_q <= StBlendLo; mphase_q <= 1'b1; end
        StBlendLo, StBlendHi, StBlendA: begin
          if (dv_start) mphase_q <= 1'b0;
          if (dv_done) begin
            mphase_q <= (st_q != StBlendA);
            st_q <= (st_q == StBlendLo) ? StBlendHi :
                    (st_q == StBlendHi) ? StBlendA : StMul;
          end
        end
        StMul: st_q <= StOut;
        StOut: if (!out_valid_q) begin
          out_valid_q <= 1'b1;
          st_q <= StIdle;
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      StRd1:   e_q[0] <= rd_q;
      StRd2:   e_q[1] <= rd_q;
      StRd3:   e_q[2] <= rd_q;
      StWait:  e_q[3] <= rd_q;
      default: ;
    endcase
    m1_q <= ba * (bs - bd);
    m2_q <= bb * bd;
    if (dv_done && st_q == StBlendLo) clo_q <= ValW'(dv_quo);
    if (dv_done && st_q == StBlendHi) chi_q <= ValW'(dv_quo);
    if (dv_done && st_q == StBlendA) fac_q <= ValW'(dv_quo);
    if (st_q == StIdle && job_valid_i && job_item_i.loss == '0) fac_q <= one_fac;
    if (st_q == StMul) prod_q <= job_item_i.loss * fac_q;
    if (st_q == StOut && !out_valid_q) begin
      if (job_item_i.operation == OpWrite) begin
        out_q <= '{factor: '0, corrected_loss: '0, saturated: 1'b0, write_done: 1'b1};
      end else begin
        out_q.factor <= fac_q;
        out_q.write_done <= 1'b0;
        if (round[2*ValW:FracBits] > (2*ValW+1-FracBits)'({ValW{1'b1}})) begin
          out_q.corrected_loss <= '1;
          out_q.saturated <= 1'b1;
        end else begin
          out_q.corrected_loss <= round[FracBits +: ValW];
          out_q.saturated <= (job_item_i.loss == '0) && one_sat;
        end
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o = out_q;

endmodule

// File: hdl/cbtc_checker.sv
// ----------------------------------------------------------------------------
// cbtc_checker
// Port-level checks of the correction block.
// ----------------------------------------------------------------------------
module cbtc_checker
  import cbtc_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_item_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("output changed while stalled");

  a_wr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.write_done |-> out_item_o.factor == '0
      && out_item_o.corrected_loss == '0 && !out_item_o.saturated)
    else $error("write acknowledge carries data");

  a_sat_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.saturated |-> out_item_o.corrected_loss == '1
      || out_item_o.factor == '1)
    else $error("saturated without clipped value");

endmodule

bind clamped_bilinear_table_correction_top cbtc_checker u_cbtc_checker (
  .clk_i, .rst_ni, .out_valid_o, .out_stall_i, .out_item_o
);

// File: tb/sv/clamped_bilinear_table_correction_checker.sv
// ----------------------------------------------------------------------------
// clamped_bilinear_table_correction_checker
// Watches the configuration port and both item channels, keeps a mirror of
// the grid registers and the correction table, predicts each result and
// compares it field by field with what the block returns, in order.
// ----------------------------------------------------------------------------
module clamped_bilinear_table_correction_checker
  import cbtc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [ValW-1:0]    cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  in_item_t           in_item_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  out_item_t          out_item_i,
  output int                 pending_o,
  output int                 fail_count_o
);

  localparam int unsigned Cols = 64;
  localparam int unsigned Rows = 64;
  localparam int unsigned FracBits = 16;

  logic [ValW-1:0] table_mirror [Rows*Cols];
  cfg_t            grid;
  out_item_t       expected_results [$];
  int              fails;

  assign pending_o    = expected_results.size();
  assign fail_count_o = fails;

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    fails++;
  endtask

  function automatic void find_bins(input longint unsigned x, lo, hi, step, pts,
                                    input longint unsigned maxpts,
                                    output longint unsigned lower, upper, off, st);
    longint unsigned last;
    longint unsigned q;
    if (pts == 0) pts = 1;
    if (pts > maxpts) pts = maxpts;
    last = pts - 1;
    st = (step == 0) ? 1 : step;
    off = 0;
    if (x <= lo) begin
      lower = 0;
      upper = 0;
    end else if (x >= hi) begin
      lower = last;
      upper = last;
    end else begin
      q = (x - lo) / st;
      if (q >= last) begin
        lower = last;
        upper = last;
      end else begin
        lower = q;
        upper = q + 1;
        off = (x - lo) - q * st;
      end
    end
  endfunction

  function automatic longint unsigned mix(input longint unsigned a, b, d, s);
    return (a * (s - d) + b * d + s / 2) / s;
  endfunction

  function automatic longint unsigned tab(input longint unsigned r, c);
    return table_mirror[(r * Cols + c) % (Rows * Cols)];
  endfunction

  function automatic out_item_t correction_of(input in_item_t it);
    out_item_t r;
    longint unsigned al, au, ao, as, ll, lu, lo, ls, c_lo, c_hi, f, prod;
    r = '0;
    if (it.loss == 0) begin
      f = 64'd1 << FracBits;
    end else begin
      find_bins(it.angle, grid.amin, grid.amax, grid.astep, grid.apts, Cols, al, au, ao, as);
      find_bins(it.loss, grid.lmin, grid.lmax, grid.lstep, grid.lpts, Rows, ll, lu, lo, ls);
      c_lo = mix(tab(ll, al), tab(lu, al), lo, ls);
      c_hi = mix(tab(ll, au), tab(lu, au), lo, ls);
      f = mix(c_lo, c_hi, ao, as);
    end
    prod = (it.loss * f + (64'd1 << (FracBits - 1))) >> FracBits;
    if (prod > 64'hFFFFFF) begin
      prod = 64'hFFFFFF;
      r.saturated = 1'b1;
    end
    r.factor = f[ValW-1:0];
    r.corrected_loss = prod[ValW-1:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      grid.amin  <= 24'd0;
      grid.amax  <= 24'd11796480;
      grid.astep <= 24'd65536;
      grid.apts  <= 7'd1;
      grid.lmin  <= 24'd0;
      grid.lmax  <= 24'hFFFFFF;
      grid.lstep <= 24'd65536;
      grid.lpts  <= 7'd1;
      expected_results.delete();
      fails = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegAngleMin:  grid.amin  <= cfg_data_i;
          RegAngleMax:  grid.amax  <= cfg_data_i;
          RegAngleStep: grid.astep <= cfg_data_i;
          RegAnglePts:  grid.apts  <= cfg_data_i[PtsW-1:0];
          RegLossMin:   grid.lmin  <= cfg_data_i;
          RegLossMax:   grid.lmax  <= cfg_data_i;
          RegLossStep:  grid.lstep <= cfg_data_i;
          RegLossPts:   grid.lpts  <= cfg_data_i[PtsW-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          report("unexpected item", out_item_i, 0);
        end else begin
          want = expected_results.pop_front();
          if (out_item_i.factor != want.factor)
            report("factor", out_item_i.factor, want.factor);
          if (out_item_i.corrected_loss != want.corrected_loss)
            report("corrected_loss", out_item_i.corrected_loss, want.corrected_loss);
          if (out_item_i.saturated != want.saturated)
            report("saturated", out_item_i.saturated, want.saturated);
          if (out_item_i.write_done != want.write_done)
            report("write_done", out_item_i.write_done, want.write_done);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (in_item_i.operation == OpWrite) begin
          table_mirror[in_item_i.row_index * Cols + in_item_i.column_index] =
            in_item_i.entry_value;
          want = '0;
          want.write_done = 1'b1;
        end else begin
          want = correction_of(in_item_i);
        end
        expected_results.insert(expected_results.size(), want);
      end
    end
  end

endmodule

// File: tb/sv/clamped_bilinear_table_correction_top_test.sv
// ----------------------------------------------------------------------------
// clamped_bilinear_table_correction_top_test
// Fills the table region that the grids reach, runs directed grid corner
// cases, then random table writes and corrections under several grid
// settings and idle patterns.
// ----------------------------------------------------------------------------
module clamped_bilinear_table_correction_top_test;
  import cbtc_pkg::*;

  localparam int unsigned AngleTop = 11796480;
  localparam int unsigned Span = 20;
  localparam int unsigned LastIdx = 63;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [ValW-1:0]    cfg_data_i;
  logic               in_valid_i;
  logic               in_stall_o;
  in_item_t           in_item_i;
  logic               out_valid_o;
  logic               out_stall_i;
  out_item_t          out_item_o;
  int                 pending;
  int                 fail_count;
  logic               in_taken;
  int                 send_idle_pct;
  int                 recv_stall_pct;
  cfg_t               grid;

  clamped_bilinear_table_correction_top u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .in_item_i,
    .out_valid_o, .out_stall_i, .out_item_o
  );

  clamped_bilinear_table_correction_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .in_item_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_item_i(out_item_o),
    .pending_o(pending), .fail_count_o(fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #(4 * 6_000_000);
    $display("CHECK FAILED");
    $finish;
  end

  always @(posedge clk_i) in_taken <= in_valid_i && !in_stall_o;

  always @(negedge clk_i) out_stall_i <= ($urandom_range(99) < recv_stall_pct);

  task automatic send(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(negedge clk_i); while (!in_taken);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic write_grid(input cfg_t g);
    logic [ValW-1:0] vals [8];
    vals = '{g.amin, g.amax, g.astep, ValW'(g.apts), g.lmin, g.lmax, g.lstep, ValW'(g.lpts)};
    drain();
    for (int i = 0; i < 8; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= CfgIdxW'(i);
      cfg_data_i  <= vals[i];
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
    grid = g;
  endtask

  task automatic put_entry(input int r, input int c, input logic [ValW-1:0] v);
    in_item_t it;
    it = in_item_t'({$urandom, $urandom});
    it.operation    = OpWrite;
    it.row_index    = IdxW'(r);
    it.column_index = IdxW'(c);
    it.entry_value  = v;
    send(it);
  endtask

  task automatic correct(input logic [ValW-1:0] a, input logic [ValW-1:0] l);
    in_item_t it;
    it = in_item_t'({$urandom, $urandom});
    it.operation = OpCorrect;
    it.angle     = a;
    it.loss      = l;
    send(it);
  endtask

  function automatic logic [ValW-1:0] factor_value();
    if ($urandom_range(9) == 0) return ValW'($urandom);
    return ValW'($urandom_range(32'h8000, 32'h20000));
  endfunction

  function automatic cfg_t pick_grid(input int unsigned top);
    cfg_t g;
    int unsigned pts, span, lo;
    pts = $urandom_range(1, Span);
    lo  = $urandom_range(0, top / 2);
    span = $urandom_range(1, top - lo);
    g.apts = PtsW'(pts);
    g.amin = ValW'(lo);
    g.astep = ValW'((pts > 1) ? span / (pts - 1) : span);
    if (g.astep == 0) g.astep = 1;
    g.amax = ValW'(lo + g.astep * (pts - 1));
    case ($urandom_range(7))
      0: g.apts = PtsW'($urandom_range(1) ? 0 : 127);
      1: g.astep = ($urandom_range(1)) ? '0 : ValW'(1);
      2: g.amax = ValW'($urandom_range(0, top));
      3: g.astep = ValW'(top);
      default: ;
    endcase
    return g;
  endfunction

  task automatic random_grid();
    cfg_t a, l, g;
    a = pick_grid(AngleTop);
    l = pick_grid(32'hFFFFFF);
    g = a;
    g.lmin = l.amin;
    g.lmax = l.amax;
    g.lstep = l.astep;
    g.lpts = l.apts;
    write_grid(g);
  endtask

  function automatic logic [ValW-1:0] near(input int unsigned lo, input int unsigned hi,
                                          input int unsigned st, input int unsigned top);
    longint unsigned a, b;
    if ($urandom_range(9) < 3) return ValW'($urandom_range(0, top));
    a = (lo > st) ? lo - st : 0;
    b = longint'(hi) + st;
    if (b > top) b = top;
    if (a > b) a = b;
    return ValW'($urandom_range(a, b));
  endfunction

  task automatic random_item();
    logic [ValW-1:0] l;
    if ($urandom_range(3) == 0) begin
      put_entry($urandom_range(63), $urandom_range(63), factor_value());
    end else begin
      l = ($urandom_range(19) == 0) ? '0 : near(grid.lmin, grid.lmax, grid.lstep, 32'hFFFFFF);
      correct(near(grid.amin, grid.amax, grid.astep, AngleTop), l);
    end
  endtask

  initial begin
    cfg_t g;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_index_i    = '0;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    in_item_i      = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    grid = '{amin: '0, amax: ValW'(AngleTop), astep: ValW'(65536), apts: PtsW'(1),
             lmin: '0, lmax: '1, lstep: ValW'(65536), lpts: PtsW'(1)};
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int r = 0; r < 64; r++)
      for (int c = 0; c < 64; c++)
        if ((r < Span || r == LastIdx) && (c < Span || c == LastIdx))
          put_entry(r, c, factor_value());

    send_idle_pct  = 12;
    recv_stall_pct = 60;
    correct(24'd65536, 24'd0);
    correct(24'(AngleTop), 24'hFFFFFF);
    put_entry(0, 0, 24'hFFFFFF);
    put_entry(63, 63, 24'h000000);
    correct(24'd0, 24'hFFFFFF);

    g = '{amin: ValW'(10 << 16), amax: ValW'(130 << 16), astep: ValW'(8 << 16),
          apts: PtsW'(16), lmin: ValW'(1 << 16), lmax: ValW'(61 << 16),
          lstep: ValW'(4 << 16), lpts: PtsW'(16)};
    write_grid(g);
    correct(24'd0, 24'd0);
    correct(24'd0, 24'd1);
    correct(24'(10 << 16), 24'(1 << 16));
    correct(24'(130 << 16), 24'(61 << 16));
    correct(24'(AngleTop), 24'hFFFFFF);
    correct(24'h3A5A5A, 24'h1C3333);
    correct(24'h855555, 24'h2AAAAA);

    g = '{amin: '0, amax: ValW'(AngleTop), astep: ValW'(1 << 16), apts: PtsW'(5),
          lmin: '0, lmax: '1, lstep: '0, lpts: PtsW'(127)};
    write_grid(g);
    correct(24'(100 << 16), 24'h000003);
    correct(24'h024000, 24'h800000);

    g = '{amin: ValW'(AngleTop), amax: '0, astep: '1, apts: '0,
          lmin: '1, lmax: '0, lstep: ValW'(1), lpts: PtsW'(1)};
    write_grid(g);
    correct(24'(AngleTop), 24'hFFFFFF);
    correct(24'h400000, 24'h7FFFFF);

    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct  = (mode == 0) ? 12 : (mode == 1) ? 60 : 0;
      recv_stall_pct = (mode == 0) ? 60 : (mode == 1) ? 12 : 0;
      for (int ph = 0; ph < 4; ph++) begin
        random_grid();
        repeat (90) random_item();
      end
    end

    drain();
    repeat (200) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: clamped_bilinear_table_correction_top.f
hdl/cbtc_pkg.sv
hdl/cbtc_div.sv
hdl/cbtc_front.sv
hdl/cbtc_back.sv
hdl/clamped_bilinear_table_correction_top.sv
hdl/cbtc_checker.sv
tb/sv/clamped_bilinear_table_correction_checker.sv
tb/sv/clamped_bilinear_table_correction_top_test.sv
